### rtl/matrix_multiply_4x4_assert.svh
// assertion macros for the matrix multiply block
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// same-cycle implication
`define MM4_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MM4_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mm4_pkg.sv
// shared constants for the matrix multiply block
`default_nettype none

package mm4_pkg;

  localparam int DIM_DEF        = 4;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 2;
  localparam int S_TDATA_W = 2 * VALUE_W;
  localparam int M_TDATA_W = 40;

endpackage

`default_nettype wire

### rtl/matrix_multiply_4x4.sv
// Q16.16 square matrix multiply on one shared multiply-accumulate unit
//
// Slave stream: one item per element pair, A in s_tdata[31:0] and B in
// s_tdata[63:32], column-major (index = row + DIM*col). The DIM*DIM-th
// item starts the product; earlier items only fill the stores.
// Master stream: DIM*DIM items of C in column-major order, tlast on the
// final one. Each element is a DIM-term dot product, rounded to nearest
// and saturated to DATA_WIDTH bits.
// Timing: each C element runs through the single multiplier in order:
// DIM reads, memory read and product registers, accumulate, round.
// s_tready is high only while loading. A result waits in the output
// register while the next element is computed; the sequencer holds
// before rounding while that register is still full, so a stalled
// receiver stalls the block without losing items.
// Reset clears the load count, sequencer and output valid; store
// contents stay undefined until loaded.
`default_nettype none

module matrix_multiply_4x4 #(
  parameter int DIM        = mm4_pkg::DIM_DEF,
  parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [mm4_pkg::S_TDATA_W-1:0]  s_tdata,  // a_value, b_value
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [mm4_pkg::M_TDATA_W-1:0]       m_tdata,  // c_value, out_row, out_col, zero pad
  output logic                                m_tlast
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int DB    = $clog2(DIM);
  localparam int PW    = 2 * DATA_WIDTH;
  localparam int ACC_W = PW + $clog2(DIM) + 1;
  localparam logic signed [ACC_W-1:0] ONE    = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] HALF   = ONE << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] LIM_HI = (ONE << (DATA_WIDTH - 1)) - ONE;
  localparam logic signed [ACC_W-1:0] LIM_LO = ~LIM_HI;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_ROUND = 4'b1000
  } state_t;

  state_t state;

  logic signed [DATA_WIDTH-1:0] left_mem  [CELLS];
  logic signed [DATA_WIDTH-1:0] right_mem [CELLS];
  logic signed [DATA_WIDTH-1:0] a_rd;
  logic signed [DATA_WIDTH-1:0] b_rd;
  logic signed [PW-1:0]         prod;
  logic signed [ACC_W-1:0]      acc;
  logic                         rd_valid;
  logic                         mul_valid;

  logic [AW-1:0] load_count;
  logic [DB-1:0] row;
  logic [DB-1:0] col;
  logic [DB-1:0] k;

  logic [DATA_WIDTH-1:0]       out_c;
  logic [DB-1:0]               out_r;
  logic [DB-1:0]               out_k;
  logic                        out_last;

  logic                         s_accept;
  logic [AW-1:0]                a_addr;
  logic [AW-1:0]                b_addr;
  logic signed [DATA_WIDTH-1:0] a_in;
  logic signed [DATA_WIDTH-1:0] b_in;
  logic signed [ACC_W-1:0]      rounded;
  logic signed [ACC_W-1:0]      shifted;
  logic [DATA_WIDTH-1:0]        sat;
  logic                         elem_last;
  logic                         out_free;

  assign s_tready = (state == S_LOAD);
  assign s_accept = s_tvalid && s_tready;
  assign a_in     = s_tdata[DATA_WIDTH-1:0];
  assign b_in     = s_tdata[mm4_pkg::VALUE_W + DATA_WIDTH - 1:mm4_pkg::VALUE_W];

  assign a_addr = AW'(row) + AW'(32'(k) * DIM);
  assign b_addr = AW'(k) + AW'(32'(col) * DIM);

  assign rounded   = acc + HALF;
  assign shifted   = rounded >>> FRAC_BITS;
  assign elem_last = (row == DB'(DIM - 1)) && (col == DB'(DIM - 1));
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    priority if (shifted > LIM_HI) begin
      sat = LIM_HI[DATA_WIDTH-1:0];
    end else if (shifted < LIM_LO) begin
      sat = LIM_LO[DATA_WIDTH-1:0];
    end else begin
      sat = shifted[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      left_mem[load_count]  <= a_in;
      right_mem[load_count] <= b_in;
    end
    a_rd <= left_mem[a_addr];
    b_rd <= right_mem[b_addr];
  end

  always_ff @(posedge clk) begin
    prod <= a_rd * b_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      mul_valid <= 1'b0;
    end else begin
      rd_valid  <= (state == S_MAC);
      mul_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (s_accept) begin
            if (load_count == AW'(CELLS - 1)) begin
              load_count <= '0;
              row        <= '0;
              col        <= '0;
              k          <= '0;
              state      <= S_MAC;
            end else begin
              load_count <= load_count + AW'(1);
            end
          end
        end
        S_MAC: begin
          if (k == DB'(DIM - 1)) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + DB'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !mul_valid) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (elem_last) begin
              state <= S_LOAD;
            end else begin
              state <= S_MAC;
              if (row == DB'(DIM - 1)) begin
                row <= '0;
                col <= col + DB'(1);
              end else begin
                row <= row + DB'(1);
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid) begin
      acc <= acc + ACC_W'(prod);
    end else if ((state == S_LOAD) || ((state == S_ROUND) && out_free)) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_ROUND) && out_free) begin
      out_c    <= sat;
      out_r    <= row;
      out_k    <= col;
      out_last <= elem_last;
    end
  end

  assign m_tdata = {4'b0000, mm4_pkg::INDEX_W'(out_k), mm4_pkg::INDEX_W'(out_r),
                    mm4_pkg::VALUE_W'(out_c)};
  assign m_tlast = out_last;

endmodule

`default_nettype wire

### rtl/mm4_checker.sv
// port-level checker for the matrix multiply block, bound to the top level
`default_nettype none

`include "matrix_multiply_4x4_assert.svh"

module mm4_checker #(
  parameter int DIM = mm4_pkg::DIM_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [mm4_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                          m_tlast
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int PCW   = $clog2(CELLS + 1);

  logic [AW-1:0]  in_cnt;
  logic [PCW-1:0] pending;
  logic           in_acc;
  logic           out_acc;
  logic           load_done;
  logic           at_end;
  logic [mm4_pkg::INDEX_W-1:0] o_row;
  logic [mm4_pkg::INDEX_W-1:0] o_col;

  assign in_acc    = s_tvalid && s_tready;
  assign out_acc   = m_tvalid && m_tready;
  assign load_done = in_acc && (in_cnt == AW'(CELLS - 1));
  assign o_row     = m_tdata[mm4_pkg::VALUE_W + mm4_pkg::INDEX_W - 1:mm4_pkg::VALUE_W];
  assign o_col     = m_tdata[mm4_pkg::VALUE_W + 2 * mm4_pkg::INDEX_W - 1:
                             mm4_pkg::VALUE_W + mm4_pkg::INDEX_W];
  assign at_end    = (o_row == mm4_pkg::INDEX_W'(DIM - 1)) &&
                     (o_col == mm4_pkg::INDEX_W'(DIM - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      pending <= '0;
    end else begin
      if (in_acc) begin
        in_cnt <= load_done ? '0 : in_cnt + AW'(1);
      end
      pending <= pending + (load_done ? PCW'(CELLS) : '0) - (out_acc ? PCW'(1) : '0);
    end
  end

  // stalled item holds
  `MM4_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled item changed")

  // tlast marks the final element of the product
  `MM4_ASSERT_NOW(a_last_index, clk, rst, m_tvalid, m_tlast == at_end,
                  "tlast does not match final element")

  // no result without a completed load
  `MM4_ASSERT_NOW(a_no_spurious, clk, rst, m_tvalid, pending != '0,
                  "result item without a loaded matrix pair")

  // loading resumes only once at most the last result is undelivered
  `MM4_ASSERT_NOW(a_ready_drained, clk, rst, s_tready, pending <= PCW'(1),
                  "input taken while product still computing")

endmodule

bind matrix_multiply_4x4 mm4_checker #(.DIM(DIM)) u_mm4_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

### test/tb_top.sv
// self-checking testbench for the 4x4 q16.16 matrix multiply block
`timescale 1ns / 1ps

module tb_top;

  localparam int DIM        = mm4_pkg::DIM_DEF;
  localparam int CELLS      = DIM * DIM;
  localparam int FRAC       = mm4_pkg::FRAC_BITS_DEF;
  localparam int MATRICES   = 17;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_TIE, MIX_Q} mix_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    int          gap;
    bit          drain;
  } pair_t;

  typedef struct packed {
    logic [31:0] c;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        last;
  } product_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [mm4_pkg::S_TDATA_W-1:0]     s_tdata = '0;  // a_value, b_value
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [mm4_pkg::M_TDATA_W-1:0]     m_tdata;       // c_value, out_row, out_col, zero pad
  logic                              m_tlast;

  matrix_multiply_4x4 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  pair_t    pair_q[$];
  product_t product_q[$];

  logic signed [31:0] left_mat[CELLS];
  logic signed [31:0] right_mat[CELLS];
  int load_idx = 0;

  int fails = 0;
  int pairs_in = 0;
  int products_done = 0;
  int results_seen = 0;
  int sat_count = 0;
  int tie_count = 0;
  int total_pairs = 0;

  // store one element pair; the last of a matrix produces the whole product
  task automatic load_pair(input logic [31:0] a, input logic [31:0] b);
    logic signed [67:0] acc;
    logic signed [67:0] ea;
    logic signed [67:0] eb;
    logic signed [67:0] rounded;
    product_t p;
    left_mat[load_idx]  = a;
    right_mat[load_idx] = b;
    load_idx++;
    if (load_idx == CELLS) begin
      load_idx = 0;
      products_done++;
      for (int col = 0; col < DIM; col++) begin
        for (int row = 0; row < DIM; row++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            ea = left_mat[row + DIM * k];
            eb = right_mat[k + DIM * col];
            acc = acc + ea * eb;
          end
          if (acc[FRAC-1:0] == 16'h8000) tie_count++;
          rounded = (acc + (68'sd1 <<< (FRAC - 1))) >>> FRAC;
          if (rounded > 68'sd2147483647) begin
            p.c = 32'h7FFF_FFFF;
            sat_count++;
          end else if (rounded < -68'sd2147483648) begin
            p.c = 32'h8000_0000;
            sat_count++;
          end else begin
            p.c = rounded[31:0];
          end
          p.row  = row[1:0];
          p.col  = col[1:0];
          p.last = (row == DIM - 1) && (col == DIM - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fails++;
    end
  endtask

  // driver
  pair_t cur;
  bit    armed = 0;
  bit    offer;
  int    gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_tready) begin
        load_pair(s_tdata[31:0], s_tdata[63:32]);
        pairs_in++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (!armed && pair_q.size() > 0) begin
          cur = pair_q.pop_front();
          gap_left = cur.gap;
          armed = 1;
        end
        if (armed) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!cur.drain || product_q.size() == 0) begin
            s_tdata <= {cur.b, cur.a};
            offer = 1'b1;
            armed = 0;
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  // monitor
  product_t want;
  int hold_left = 0;
  int calm_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (product_q.size() == 0) begin
          $error("unexpected result: c_value %h row %0d col %0d", m_tdata[31:0],
                 m_tdata[33:32], m_tdata[35:34]);
          fails++;
        end else begin
          want = product_q.pop_front();
          check_field("c_value", want.c, m_tdata[31:0]);
          check_field("out_row", 32'(want.row), 32'(m_tdata[33:32]));
          check_field("out_col", 32'(want.col), 32'(m_tdata[35:34]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
        if (results_seen == 20) begin
          hold_left = LONG_HOLD;
        end else if (calm_left > 0) begin
          calm_left--;
          hold_left = 0;
        end else begin
          if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
          hold_left = $urandom_range(0, 15);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL matrix_multiply_4x4");
        $finish;
      end
    end
  end

  int calm_gaps = 0;

  function automatic int draw_gap();
    if (calm_gaps > 0) begin
      calm_gaps--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_gaps = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [31:0] draw_value(input mix_t mix, input bit right);
    logic [31:0] picks[5];
    picks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    case (mix)
      MIX_EXTREME: begin
        return ($urandom_range(0, 3) == 0) ? picks[$urandom_range(0, 4)] :
               picks[$urandom_range(0, 1)];
      end
      MIX_TIE: begin
        if (right) return 32'(int'($urandom_range(0, 511)) - 256) << 14;
        return 32'(int'($urandom_range(0, 8)) - 4);
      end
      MIX_Q: begin
        return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  task automatic queue_matrix(input mix_t mix, input bit drain_first);
    pair_t p;
    for (int i = 0; i < CELLS; i++) begin
      p.a     = draw_value(mix, 1'b0);
      p.b     = draw_value(mix, 1'b1);
      p.gap   = draw_gap();
      p.drain = drain_first && (i == 0);
      pair_q.push_back(p);
    end
  endtask

  initial begin
    logic [31:0] specials[CELLS];
    pair_t p;
    specials = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                 32'hFFFF_8000, 32'h7FFF_0000, 32'h8001_0000, 32'h0001_8000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'h4000_0000};
    for (int i = 0; i < CELLS; i++) begin
      p.a     = specials[i];
      p.b     = specials[(i * 5 + 3) % CELLS];
      p.gap   = draw_gap();
      p.drain = 0;
      pair_q.push_back(p);
    end
    for (int m = 0; m < MATRICES - 1; m++) begin
      queue_matrix(mix_t'(m % 4), m == 8);
    end
    total_pairs = pair_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pairs_in < total_pairs) @(posedge clk);
    while (product_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (product_q.size() > 0) begin
      $error("%0d expected results never arrived", product_q.size());
      fails++;
    end
    $display("summary: %0d matrix products from %0d element pairs, %0d results checked",
             products_done, pairs_in, results_seen);
    $display("summary: %0d saturated elements, %0d exact rounding ties, %0d failures",
             sat_count, tie_count, fails);
    if (fails == 0) begin
      $display("PASS matrix_multiply_4x4");
    end else begin
      $display("FAIL matrix_multiply_4x4");
    end
    $finish;
  end

endmodule
